[sv/bst_pkg.sv]
// ----------------------------------------------------------------------------
// Bond slot table package
// Shared field widths, operation and status codes and the result word layout.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int OP_W        = 3;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int CD_W        = 8;
    localparam int STATUS_W    = 2;
    localparam int BC_W        = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_PARTICLE_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN_TICKS = 1'b1;

    localparam logic [CD_W-1:0] COOLDOWN_RESET = 8'd30;

    typedef struct packed {
        logic [CD_W-1:0]     cooldown_left;
        logic [BC_W-1:0]     bond_count;
        logic                bonded;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

[sv/bst_row_mem.sv]
// ----------------------------------------------------------------------------
// Bond slot table row memory
// One particle row per entry, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bst_row_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int W     = 55
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/bst_engine.sv]
// ----------------------------------------------------------------------------
// Bond slot table engine
// Sequencer that reads, modifies and writes back particle rows for each word.
// ----------------------------------------------------------------------------
module bst_engine #(
    parameter int MAX_PARTICLES      = 1024,
    parameter int SLOTS_PER_PARTICLE = 4,
    parameter int AW                 = $clog2(MAX_PARTICLES),
    parameter int LIM_W              = 11,
    parameter int ROW_W              = bst_pkg::CD_W + $clog2(SLOTS_PER_PARTICLE + 1)
                                       + SLOTS_PER_PARTICLE * (1 + bst_pkg::IDX_W)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bst_pkg::OP_W-1:0]   in_op,
    input  logic [bst_pkg::IDX_W-1:0]  in_a,
    input  logic [bst_pkg::IDX_W-1:0]  in_b,
    input  logic [LIM_W-1:0]           lim,
    input  logic [bst_pkg::CD_W-1:0]   ticks,
    output logic                       res_valid,
    input  logic                       res_ready,
    output bst_pkg::result_t           res,
    output logic                       mem_rd_en,
    output logic [AW-1:0]              mem_rd_addr,
    input  logic [ROW_W-1:0]           mem_rd_data,
    output logic                       mem_wr_en,
    output logic [AW-1:0]              mem_wr_addr,
    output logic [ROW_W-1:0]           mem_wr_data
);

    import bst_pkg::*;

    localparam int S      = SLOTS_PER_PARTICLE;
    localparam int TOT_W  = $clog2(S + 1);
    localparam int SIDX_W = (S > 1) ? $clog2(S) : 1;
    localparam logic [AW-1:0]     LAST_ROW  = AW'(MAX_PARTICLES - 1);
    localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(S - 1);

    typedef struct packed {
        logic [CD_W-1:0]            cooldown;
        logic [TOT_W-1:0]           total;
        logic [S-1:0]               valid;
        logic [S-1:0][IDX_W-1:0]    partner;
    } row_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_PAIR,
        S_WR_A,
        S_WR_B,
        S_QUERY,
        S_CL_LATCH,
        S_CL_SLOT,
        S_CL_PART,
        S_CL_WR,
        S_TICK,
        S_WIPE,
        S_DONE
    } state_t;

    function automatic row_t drop_first(row_t r, logic [IDX_W-1:0] p);
        row_t o;
        logic hit;
        o   = r;
        hit = 1'b0;
        for (int s = 0; s < S; s++)
        begin
            if (!hit && r.valid[s] && r.partner[s] == p)
            begin
                o.valid[s]   = 1'b0;
                o.partner[s] = '0;
                hit          = 1'b1;
            end
        end
        if (hit && r.total != '0)
        begin
            o.total = r.total - 1'b1;
        end
        return o;
    endfunction

    function automatic row_t take_slot(row_t r, logic [IDX_W-1:0] p);
        row_t o;
        logic hit;
        o   = r;
        hit = 1'b0;
        for (int s = 0; s < S; s++)
        begin
            if (!hit && !r.valid[s])
            begin
                o.valid[s]   = 1'b1;
                o.partner[s] = p;
                hit          = 1'b1;
            end
        end
        o.total = TOT_W'(r.total + 1'b1);
        return o;
    endfunction

    function automatic logic pair_hit(row_t r, logic [IDX_W-1:0] p);
        logic hit;
        hit = 1'b0;
        for (int s = 0; s < S; s++)
        begin
            if (r.valid[s] && r.partner[s] == p)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    state_t            state_reg;
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  b_reg;
    logic              a_ok_reg;
    row_t              row_a_reg;
    row_t              row_b_reg;
    logic [SIDX_W-1:0] slot_reg;
    logic [AW-1:0]     part_addr_reg;
    logic [AW-1:0]     cnt_reg;
    logic              sweep_on_reg;
    logic              pipe_vld_reg;
    logic [AW-1:0]     pipe_idx_reg;
    result_t           res_reg;

    row_t              rd_row;
    row_t              pair_new_a;
    row_t              pair_new_b;
    logic              pair_full;
    row_t              part_new;
    row_t              tick_row;
    logic              slot_hit;
    logic              in_a_ok;
    logic              in_b_ok;
    logic              in_err;
    logic              accept;
    logic [AW-1:0]     a_addr;
    logic [AW-1:0]     b_addr;

    assign rd_row    = row_t'(mem_rd_data);
    assign in_a_ok   = LIM_W'(in_a) < lim;
    assign in_b_ok   = LIM_W'(in_b) < lim;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign a_addr    = AW'(a_reg);
    assign b_addr    = AW'(b_reg);
    assign slot_hit  = row_a_reg.valid[slot_reg]
                       && (LIM_W'(row_a_reg.partner[slot_reg]) < lim);

    always_comb
    begin
        unique case (in_op)
            OP_ADD:              in_err = !in_a_ok || !in_b_ok || (in_a == in_b);
            OP_REMOVE, OP_QUERY: in_err = !in_a_ok || !in_b_ok;
            OP_CLEAR:            in_err = !in_a_ok;
            default:             in_err = 1'b0;
        endcase
    end

    always_comb
    begin
        pair_full  = 1'b0;
        pair_new_a = row_a_reg;
        pair_new_b = rd_row;
        if (op_reg == OP_ADD)
        begin
            pair_full = (&row_a_reg.valid) || (&rd_row.valid);
            if (!pair_full)
            begin
                pair_new_a = take_slot(row_a_reg, b_reg);
                pair_new_b = take_slot(rd_row, a_reg);
            end
        end
        else
        begin
            pair_new_a          = drop_first(row_a_reg, b_reg);
            pair_new_a.cooldown = ticks;
            pair_new_b          = drop_first(rd_row, a_reg);
            pair_new_b.cooldown = ticks;
        end
    end

    always_comb
    begin
        part_new          = drop_first(rd_row, a_reg);
        part_new.cooldown = ticks;
        tick_row          = rd_row;
        if (rd_row.cooldown != '0)
        begin
            tick_row.cooldown = rd_row.cooldown - 1'b1;
        end
    end

    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = a_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = a_addr;
        mem_wr_data = '0;
        unique case (state_reg)
            S_RD_A:
            begin
                mem_rd_en = 1'b1;
            end
            S_RD_B:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = b_addr;
            end
            S_WR_A, S_CL_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = row_a_reg;
            end
            S_WR_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = b_addr;
                mem_wr_data = row_b_reg;
            end
            S_CL_SLOT:
            begin
                mem_rd_en   = slot_hit;
                mem_rd_addr = AW'(row_a_reg.partner[slot_reg]);
            end
            S_CL_PART:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = part_addr_reg;
                mem_wr_data = part_new;
            end
            S_TICK:
            begin
                mem_rd_en   = sweep_on_reg;
                mem_rd_addr = cnt_reg;
                mem_wr_en   = pipe_vld_reg;
                mem_wr_addr = pipe_idx_reg;
                mem_wr_data = tick_row;
            end
            S_INIT, S_WIPE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            op_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            a_ok_reg      <= 1'b0;
            row_a_reg     <= '0;
            row_b_reg     <= '0;
            slot_reg      <= '0;
            part_addr_reg <= '0;
            cnt_reg       <= '0;
            sweep_on_reg  <= 1'b0;
            pipe_vld_reg  <= 1'b0;
            pipe_idx_reg  <= '0;
            res_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    if (cnt_reg == LAST_ROW)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg                <= in_op;
                        a_reg                 <= in_a;
                        b_reg                 <= in_b;
                        a_ok_reg              <= in_a_ok;
                        res_reg.status        <= in_err ? ST_RANGE : ST_OK;
                        res_reg.bonded        <= 1'b0;
                        res_reg.bond_count    <= '0;
                        res_reg.cooldown_left <= '0;
                        unique case (in_op)
                            OP_ADD, OP_REMOVE, OP_QUERY, OP_CLEAR:
                            begin
                                state_reg <= in_err ? S_DONE : S_RD_A;
                            end
                            OP_TICK:
                            begin
                                cnt_reg      <= '0;
                                sweep_on_reg <= 1'b1;
                                pipe_vld_reg <= 1'b0;
                                state_reg    <= S_TICK;
                            end
                            OP_RESET:
                            begin
                                cnt_reg   <= '0;
                                state_reg <= S_WIPE;
                            end
                            default:
                            begin
                                state_reg <= in_a_ok ? S_RD_A : S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_A:
                begin
                    priority case (op_reg)
                        OP_ADD, OP_REMOVE: state_reg <= S_RD_B;
                        OP_CLEAR:          state_reg <= S_CL_LATCH;
                        default:           state_reg <= S_QUERY;
                    endcase
                end
                S_RD_B:
                begin
                    row_a_reg <= rd_row;
                    state_reg <= S_PAIR;
                end
                S_PAIR:
                begin
                    row_a_reg             <= pair_new_a;
                    row_b_reg             <= pair_new_b;
                    res_reg.status        <= pair_full ? ST_FULL : ST_OK;
                    res_reg.bonded        <= 1'b0;
                    res_reg.bond_count    <= BC_W'(pair_new_a.total);
                    res_reg.cooldown_left <= pair_new_a.cooldown;
                    state_reg             <= pair_full ? S_DONE : S_WR_A;
                end
                S_WR_A:
                begin
                    state_reg <= S_WR_B;
                end
                S_WR_B:
                begin
                    state_reg <= S_DONE;
                end
                S_QUERY:
                begin
                    res_reg.status        <= ST_OK;
                    res_reg.bonded        <= (op_reg == OP_QUERY) && pair_hit(rd_row, b_reg);
                    res_reg.bond_count    <= BC_W'(rd_row.total);
                    res_reg.cooldown_left <= rd_row.cooldown;
                    state_reg             <= S_DONE;
                end
                S_CL_LATCH:
                begin
                    row_a_reg <= rd_row;
                    slot_reg  <= '0;
                    state_reg <= S_CL_SLOT;
                end
                S_CL_SLOT:
                begin
                    if (slot_hit)
                    begin
                        part_addr_reg <= AW'(row_a_reg.partner[slot_reg]);
                        state_reg     <= S_CL_PART;
                    end
                    else if (slot_reg == LAST_SLOT)
                    begin
                        state_reg <= S_CL_WR;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_CL_PART:
                begin
                    row_a_reg.valid[slot_reg]   <= 1'b0;
                    row_a_reg.partner[slot_reg] <= '0;
                    row_a_reg.cooldown          <= ticks;
                    if (row_a_reg.total != '0)
                    begin
                        row_a_reg.total <= row_a_reg.total - 1'b1;
                    end
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_reg <= S_CL_WR;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_CL_SLOT;
                    end
                end
                S_CL_WR:
                begin
                    res_reg.status        <= ST_OK;
                    res_reg.bonded        <= 1'b0;
                    res_reg.bond_count    <= BC_W'(row_a_reg.total);
                    res_reg.cooldown_left <= row_a_reg.cooldown;
                    state_reg             <= S_DONE;
                end
                S_TICK:
                begin
                    pipe_vld_reg <= sweep_on_reg;
                    pipe_idx_reg <= cnt_reg;
                    if (sweep_on_reg)
                    begin
                        if (cnt_reg == LAST_ROW)
                        begin
                            sweep_on_reg <= 1'b0;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    if (pipe_vld_reg && a_ok_reg && pipe_idx_reg == a_addr)
                    begin
                        res_reg.bond_count    <= BC_W'(tick_row.total);
                        res_reg.cooldown_left <= tick_row.cooldown;
                    end
                    if (!sweep_on_reg && pipe_vld_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_WIPE:
                begin
                    if (cnt_reg == LAST_ROW)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/bond_slot_table_top.sv]
// ----------------------------------------------------------------------------
// Bond slot table top level
// Bond bookkeeping for a set of particles with partner slots and cooldowns.
// ----------------------------------------------------------------------------
// Usage: each word on the s_axis channel carries one operation (add, remove,
// query, clear particle, tick, reset table) and yields exactly one result word
// on the m_axis channel with a status, the query flag and the bond count and
// cooldown of particle_a. The configuration port sets the number of particles
// in use and the cooldown loaded on a remove or clear; write it only while
// idle. Every particle row lives in one memory with a registered read,
// and one operation is worked on at a time.
// A query reads the row of particle_a; an add or remove reads both rows and
// writes them back unless an add finds a row full; a clear also updates the
// row of each bonded partner; a tick or a table reset passes over every row.
// All of this runs through the single memory read port and write port.
// After reset the block clears every memory row with s_axis_tready low.
// A stalled result is held in the output register while the next word is
// already accepted and worked on.
// ----------------------------------------------------------------------------
module bond_slot_table_top #(
    parameter int MAX_PARTICLES      = 1024,
    parameter int SLOTS_PER_PARTICLE = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation[2:0], particle_a[12:3], particle_b[22:13], zero pad
    input  logic [bst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], bonded[2], bond_count[5:3], cooldown_left[13:6], zero pad
    output logic [bst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [bst_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [bst_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    import bst_pkg::*;

    localparam int AW     = $clog2(MAX_PARTICLES);
    localparam int MLIM_W = $clog2(MAX_PARTICLES + 1);
    localparam int LIM_W  = (MLIM_W > CNT_W) ? MLIM_W : CNT_W;
    localparam int TOT_W  = $clog2(SLOTS_PER_PARTICLE + 1);
    localparam int ROW_W  = CD_W + TOT_W + SLOTS_PER_PARTICLE * (1 + IDX_W);

    logic [CNT_W-1:0] particle_count_reg;
    logic [CD_W-1:0]  cooldown_ticks_reg;
    logic [LIM_W-1:0] lim;

    logic             res_valid;
    logic             res_ready;
    result_t          res;
    result_t          out_reg;
    logic             out_valid_reg;

    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [ROW_W-1:0] mem_rd_data;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [ROW_W-1:0] mem_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_count_reg <= '0;
            cooldown_ticks_reg <= COOLDOWN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_PARTICLE_COUNT: particle_count_reg <= cfg_wr_data;
                REG_COOLDOWN_TICKS: cooldown_ticks_reg <= cfg_wr_data[CD_W-1:0];
                default:            particle_count_reg <= particle_count_reg;
            endcase
        end
    end

    assign lim = (LIM_W'(particle_count_reg) < LIM_W'(MAX_PARTICLES))
                 ? LIM_W'(particle_count_reg) : LIM_W'(MAX_PARTICLES);

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_reg);

    bst_engine #(
        .MAX_PARTICLES      (MAX_PARTICLES),
        .SLOTS_PER_PARTICLE (SLOTS_PER_PARTICLE),
        .AW                 (AW),
        .LIM_W              (LIM_W),
        .ROW_W              (ROW_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tdata[OP_W-1:0]),
        .in_a        (s_axis_tdata[OP_W+IDX_W-1:OP_W]),
        .in_b        (s_axis_tdata[OP_W+2*IDX_W-1:OP_W+IDX_W]),
        .lim         (lim),
        .ticks       (cooldown_ticks_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    bst_row_mem #(
        .DEPTH (MAX_PARTICLES),
        .AW    (AW),
        .W     (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule
